FILE: sv/tcppq_pkg.sv
// Shared types and constants for the two-class priority packet queue.
package tcppq_pkg;

   localparam int PAYLOAD_WIDTH = 32;
   localparam int OCC_WIDTH     = 5;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_SEND    = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_SENT     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                     enq;
      logic                     send;
      logic                     mode;
      logic                     any_hit;
      logic                     prio;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } cmd_type;

   // handed from a cell to its younger neighbor
   typedef struct packed {
      logic                     prev_valid;
      logic                     hit;
      logic                     sel_prio;
      logic [PAYLOAD_WIDTH-1:0] sel_payload;
   } link_type;

   // contents of one slot, handed to the older neighbor on a shift
   typedef struct packed {
      logic                     valid;
      logic                     prio;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } slot_type;

endpackage

FILE: sv/tcppq_cell.sv
// One queue slot: holds a packet, finds the oldest high-priority entry, shifts on send.
module tcppq_cell #(
   parameter bit IS_HEAD = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcppq_pkg::cmd_type   cmd,
   input  tcppq_pkg::link_type  link_in,
   output tcppq_pkg::link_type  link_out,
   input  tcppq_pkg::slot_type  younger_in,
   output tcppq_pkg::slot_type  slot_out
);

   logic                                valid_ff;
   logic                                valid_in;
   logic                                prio_ff;
   logic                                prio_in;
   logic [tcppq_pkg::PAYLOAD_WIDTH-1:0] payload_ff;
   logic [tcppq_pkg::PAYLOAD_WIDTH-1:0] payload_in;
   logic                                found;
   logic                                hit_out;
   logic                                selected;
   logic                                shift;
   logic                                write;

   assign found    = cmd.mode & valid_ff & prio_ff & ~link_in.hit;
   assign hit_out  = link_in.hit | found;
   assign selected = valid_ff & (cmd.any_hit ? found : IS_HEAD);
   assign shift    = cmd.send & (~cmd.any_hit | hit_out);
   assign write    = cmd.enq & ~valid_ff & link_in.prev_valid;

   always_comb begin
      valid_in   = valid_ff;
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (shift) begin
         valid_in   = younger_in.valid;
         prio_in    = younger_in.prio;
         payload_in = younger_in.payload;
      end else if (write) begin
         valid_in   = 1'b1;
         prio_in    = cmd.prio;
         payload_in = cmd.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign link_out.prev_valid  = valid_ff;
   assign link_out.hit         = hit_out;
   assign link_out.sel_prio    = link_in.sel_prio | (selected & prio_ff);
   assign link_out.sel_payload = link_in.sel_payload
                                 | ({tcppq_pkg::PAYLOAD_WIDTH{selected}} & payload_ff);

   assign slot_out.valid   = valid_ff;
   assign slot_out.prio    = prio_ff;
   assign slot_out.payload = payload_ff;

endmodule

FILE: sv/two_class_priority_packet_queue_unit.sv
// Top level of the two-class strict priority packet queue.
//
// Requests arrive on req_*: req_tuser[0] is the opcode (enqueue or send),
// req_tuser[1] the priority class of an enqueued packet, req_tdata the payload.
// Every request gives exactly one response on rsp_*: rsp_tuser carries status
// and the class of a sent packet, rsp_tdata the sent payload and the occupancy
// after the request.
// Packets sit in a row of cells, oldest in cell 0. An enqueue fills the first
// empty cell; a send takes the selected cell and every younger cell loads its
// neighbor's contents in the same cycle. csr_wr_en/csr_wr_data set the
// priority mode (1 = oldest high-priority packet first, 0 = oldest overall).
// The response is registered and valid in the cycle after the request is taken;
// one request is taken per cycle unless a stalled response holds req_tready low.
// The selection is a combinational ripple through all QUEUE_DEPTH cells, which sets the clock limit.
// Reset empties the queue and sets priority mode. A stalled response is held
// in its register; a new request is taken in the cycle the response leaves.
module two_class_priority_packet_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // payload[31:0]
   input  logic [1:0]  req_tuser,   // opcode[0], high_priority[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // sent_payload[31:0], occupancy[36:32], zero[39:37]
   output logic [2:0]  rsp_tuser,   // status[1:0], sent_high_priority[2]
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   logic                  mode_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic [39:0]           rsp_data_ff;
   logic [39:0]           rsp_data_in;
   logic [2:0]            rsp_user_ff;
   logic [2:0]            rsp_user_in;
   logic                  accept;
   logic                  is_send;
   logic                  empty;
   logic                  full;
   tcppq_pkg::status_type status;
   tcppq_pkg::cmd_type    cmd;
   tcppq_pkg::link_type   link [QUEUE_DEPTH+1];
   tcppq_pkg::slot_type   slot [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH-1:0] valid_vec;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign is_send    = (req_tuser[0] == tcppq_pkg::OP_SEND);
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CountWidth'(QUEUE_DEPTH));

   assign cmd.enq     = accept & ~is_send & ~full;
   assign cmd.send    = accept & is_send & ~empty;
   assign cmd.mode    = mode_ff;
   assign cmd.any_hit = link[QUEUE_DEPTH].hit;
   assign cmd.prio    = req_tuser[1];
   assign cmd.payload = req_tdata;

   assign link[0].prev_valid  = 1'b1;
   assign link[0].hit         = 1'b0;
   assign link[0].sel_prio    = 1'b0;
   assign link[0].sel_payload = '0;
   assign slot[QUEUE_DEPTH]   = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tcppq_cell #(
         .IS_HEAD (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .younger_in (slot[i+1]),
         .slot_out   (slot[i])
      );
      assign valid_vec[i] = slot[i].valid;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.send) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      if (is_send) begin
         status = empty ? tcppq_pkg::ST_EMPTY : tcppq_pkg::ST_SENT;
      end else begin
         status = full ? tcppq_pkg::ST_FULL : tcppq_pkg::ST_ENQUEUED;
      end
      rsp_data_in = {3'b000, tcppq_pkg::OCC_WIDTH'(count_in), 32'h0};
      rsp_user_in = {1'b0, status};
      if (cmd.send) begin
         rsp_data_in[31:0] = link[QUEUE_DEPTH].sel_payload;
         rsp_user_in[2]    = link[QUEUE_DEPTH].sel_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("request taken without a response");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("occupied cells disagree with packet count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("packet count above queue depth");

   a_full_no_store: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_send && full) |=> $stable(count_ff))
      else $error("dropped packet changed the queue");

endmodule

FILE: bench/two_class_priority_packet_queue_unit_test.sv
// Testbench for the two-class priority packet queue: directed and random requests,
// scored against an in-bench model of the queue.
`timescale 1ns / 1ps

module two_class_priority_packet_queue_unit_test;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic        prio;
      logic [31:0] payload;
   } held_packet_type;

   typedef struct packed {
      tcppq_pkg::status_type status;
      logic                  sent_prio;
      logic [31:0]           sent_payload;
      logic [4:0]            occupancy;
   } queue_response_type;

   class send_order_model;
      bit                 priority_mode;
      held_packet_type    queued_packets[$];
      queue_response_type awaited_responses[$];
      int                 errors;

      function void clear();
         priority_mode = 1'b1;
         queued_packets.delete();
         awaited_responses.delete();
         errors = 0;
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      function void note_request(tcppq_pkg::opcode_type op, logic prio, logic [31:0] data);
         queue_response_type r;
         held_packet_type    pkt;
         int                 pick;
         r = '0;
         if (op == tcppq_pkg::OP_ENQUEUE) begin
            if (queued_packets.size() >= DEPTH) begin
               r.status = tcppq_pkg::ST_FULL;
            end else begin
               pkt.prio = prio;
               pkt.payload = data;
               queued_packets.push_back(pkt);
               r.status = tcppq_pkg::ST_ENQUEUED;
            end
         end else if (queued_packets.size() == 0) begin
            r.status = tcppq_pkg::ST_EMPTY;
         end else begin
            pick = 0;
            if (priority_mode) begin
               for (int i = queued_packets.size() - 1; i >= 0; i--) begin
                  if (queued_packets[i].prio) pick = i;
               end
            end
            pkt = queued_packets[pick];
            queued_packets.delete(pick);
            r.status = tcppq_pkg::ST_SENT;
            r.sent_prio = pkt.prio;
            r.sent_payload = pkt.payload;
         end
         r.occupancy = 5'(queued_packets.size());
         awaited_responses.push_back(r);
      endfunction

      task report(string field, logic [39:0] got, logic [39:0] want);
         $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
         errors++;
      endtask

      task check_response(logic [39:0] tdata, logic [2:0] tuser);
         queue_response_type want;
         if (awaited_responses.size() == 0) begin
            report("unexpected response", {tuser, tdata[36:0]}, '0);
         end else begin
            want = awaited_responses.pop_front();
            if (tuser[1:0] !== want.status)
               report("status", 40'(tuser[1:0]), 40'(want.status));
            if (tuser[2] !== want.sent_prio)
               report("sent class", 40'(tuser[2]), 40'(want.sent_prio));
            if (tdata[31:0] !== want.sent_payload)
               report("sent payload", 40'(tdata[31:0]), 40'(want.sent_payload));
            if (tdata[36:32] !== want.occupancy)
               report("occupancy", 40'(tdata[36:32]), 40'(want.occupancy));
            if (tdata[39:37] !== 3'b000) report("tdata pad", 40'(tdata[39:37]), '0);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // payload[31:0]
   logic [1:0]  req_tuser;    // opcode[0], high_priority[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // sent_payload[31:0], occupancy[36:32], zero[39:37]
   logic [2:0]  rsp_tuser;    // status[1:0], sent_high_priority[2]
   logic        csr_wr_en;
   logic        csr_wr_data;

   send_order_model order_model;
   bit              full_rate;

   two_class_priority_packet_queue_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      if (full_rate || $urandom_range(0, 4) == 0) return 0;
      return $urandom_range(0, 12);
   endfunction

   task automatic issue_request(input tcppq_pkg::opcode_type op, input logic prio,
                                input logic [31:0] data);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {prio, op};
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      order_model.note_request(op, prio, data);
   endtask

   // only while nothing is in flight
   task automatic write_priority_mode(input logic mode);
      req_tvalid <= 1'b0;
      while (order_model.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      order_model.priority_mode = mode;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(input int count);
      int                    run_left;
      int                    enq_pct;
      int                    prio_pct;
      logic [31:0]           data;
      tcppq_pkg::opcode_type op;
      run_left = 0;
      enq_pct = 50;
      prio_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
               0: enq_pct = 85;
               1: enq_pct = 15;
               2: enq_pct = 55;
               default: enq_pct = 45;
            endcase
            prio_pct = $urandom_range(0, 4) * 25;
         end
         run_left--;
         op = ($urandom_range(0, 99) < enq_pct) ? tcppq_pkg::OP_ENQUEUE : tcppq_pkg::OP_SEND;
         case ($urandom_range(0, 15))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            default: data = $urandom;
         endcase
         issue_request(op, $urandom_range(0, 99) < prio_pct, data);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         order_model.check_response(rsp_tdata, rsp_tuser);
   end

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      bit phase_mode[6];
      phase_mode  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      order_model = new();
      order_model.clear();
      full_rate   = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // priority mode out of reset
      issue_request(tcppq_pkg::OP_SEND, 1'b0, 32'h0);
      issue_request(tcppq_pkg::OP_ENQUEUE, 1'b0, 32'h0000_0000);
      issue_request(tcppq_pkg::OP_ENQUEUE, 1'b1, 32'hFFFF_FFFF);
      issue_request(tcppq_pkg::OP_ENQUEUE, 1'b0, 32'hA5A5_A5A5);
      issue_request(tcppq_pkg::OP_ENQUEUE, 1'b1, 32'h5A5A_5A5A);
      issue_request(tcppq_pkg::OP_SEND, 1'b1, 32'hFFFF_FFFF);
      issue_request(tcppq_pkg::OP_SEND, 1'b0, 32'h0);
      // no high class left: oldest goes
      issue_request(tcppq_pkg::OP_SEND, 1'b0, 32'h0);
      for (int i = 0; i < DEPTH - 1; i++)
         issue_request(tcppq_pkg::OP_ENQUEUE, i[0], $urandom);
      // full: dropped
      issue_request(tcppq_pkg::OP_ENQUEUE, 1'b1, 32'hDEAD_BEEF);
      write_priority_mode(1'b0);
      issue_request(tcppq_pkg::OP_SEND, 1'b0, 32'h0);
      issue_request(tcppq_pkg::OP_SEND, 1'b1, 32'h0);

      foreach (phase_mode[p]) begin
         write_priority_mode(phase_mode[p]);
         full_rate = (p == 2);
         run_random_phase(250);
      end
      full_rate = 1'b0;

      req_tvalid <= 1'b0;
      while (order_model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (order_model.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
